// ===== design/teg_pkg.sv =====
// ----------------------------------------------------------------------------
// teg_pkg
// Shared constants, codes and controller/datapath handshake types for the
// trapezoid envelope generator.
// ----------------------------------------------------------------------------
package teg_pkg;

  // default widths
  localparam int TIME_WIDTH_DEF  = 24;
  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int CMD_WIDTH       = 2;
  localparam int DELTA_WIDTH     = 16;
  localparam int PHASE_WIDTH     = 2;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int CFG_DATA_WIDTH_DEF =
      (LEVEL_WIDTH_DEF > TIME_WIDTH_DEF + 1) ? LEVEL_WIDTH_DEF : TIME_WIDTH_DEF + 1;

  // command codes
  localparam logic [CMD_WIDTH-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_ATTACK  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_OFF     = 2'd3;

  // phase codes
  localparam logic [PHASE_WIDTH-1:0] PH_OFF     = 2'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_ATTACK  = 2'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_SUSTAIN = 2'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_RELEASE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEVEL_MIN   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEVEL_MAX   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ATTACK_LEN  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RELEASE_LEN = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SUSTAIN_LEN = 3'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;     // capture the incoming word
    logic eval;      // start value evaluation: bypass or load dividend
    logic div_step;  // one restoring division step
    logic div_done;  // fold quotient into the current value
    logic apply;     // apply the latched command to the envelope state
    logic out_load;  // load the result register
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_pre;  // command needs the value of the present state first
    logic bypass;    // current value known without division
  } sts_t;

endpackage

// ===== design/teg_ifs.sv =====
// ----------------------------------------------------------------------------
// teg interfaces
// Valid/ready channels for command words, result words and register writes.
// ----------------------------------------------------------------------------
interface teg_in_if;
  import teg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_WIDTH-1:0]   command;
  logic [DELTA_WIDTH-1:0] delta_time;

  modport source (output valid, command, delta_time, input ready);
  modport sink   (input valid, command, delta_time, output ready);
endinterface

interface teg_out_if #(
  parameter int LEVEL_WIDTH = teg_pkg::LEVEL_WIDTH_DEF
);
  import teg_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [LEVEL_WIDTH-1:0] level;
  logic [PHASE_WIDTH-1:0]        phase_out;

  modport source (output valid, level, phase_out, input ready);
  modport sink   (input valid, level, phase_out, output ready);
endinterface

interface teg_cfg_if #(
  parameter int DATA_WIDTH = teg_pkg::CFG_DATA_WIDTH_DEF
);
  import teg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/teg_datapath.sv =====
// ----------------------------------------------------------------------------
// teg_datapath
// Envelope state, configuration registers, interpolation multiplier,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module teg_datapath #(
  parameter int TIME_WIDTH  = teg_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = teg_pkg::LEVEL_WIDTH_DEF,
  parameter int CFG_DW      = teg_pkg::CFG_DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  teg_pkg::ctl_t                      ctl,
  output teg_pkg::sts_t                      sts,
  input  logic [teg_pkg::CMD_WIDTH-1:0]      command,
  input  logic [teg_pkg::DELTA_WIDTH-1:0]    delta_time,
  input  logic                               cfg_we,
  input  logic [teg_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]                  cfg_data,
  output logic signed [LEVEL_WIDTH-1:0]      level,
  output logic [teg_pkg::PHASE_WIDTH-1:0]    phase_out
);
  import teg_pkg::*;

  localparam int EW = TIME_WIDTH + 1;
  localparam int SW = ((EW > DELTA_WIDTH) ? EW : DELTA_WIDTH) + 1;
  localparam int PW = LEVEL_WIDTH + TIME_WIDTH;
  localparam logic [EW-1:0] ELAPSED_ALL = {EW{1'b1}};

  // configuration
  logic signed [LEVEL_WIDTH-1:0] level_min;
  logic signed [LEVEL_WIDTH-1:0] level_max;
  logic [TIME_WIDTH-1:0]         attack_len;
  logic [TIME_WIDTH-1:0]         release_len;
  logic [EW-1:0]                 sustain_len;

  // envelope state
  logic [PHASE_WIDTH-1:0]        phase;
  logic [EW-1:0]                 elapsed;
  logic signed [LEVEL_WIDTH-1:0] seg_start;
  logic signed [LEVEL_WIDTH-1:0] seg_target;

  // latched command word
  logic [CMD_WIDTH-1:0]          cmd_q;
  logic [DELTA_WIDTH-1:0]        delta_q;

  // evaluation
  logic signed [LEVEL_WIDTH-1:0] cur_value;
  logic                          neg;
  logic [PW-1:0]                 div_reg;

  logic [TIME_WIDTH-1:0]         dur;
  logic                          at_target;
  logic signed [LEVEL_WIDTH:0]   diff;
  logic [LEVEL_WIDTH:0]          diff_abs;
  logic [PW-1:0]                 product;
  logic [TIME_WIDTH:0]           trial;
  logic                          trial_ge;
  logic [TIME_WIDTH:0]           trial_rem;
  logic signed [LEVEL_WIDTH:0]   interp;

  // next state from apply
  logic [PHASE_WIDTH-1:0]        phase_next;
  logic [EW-1:0]                 elapsed_next;
  logic signed [LEVEL_WIDTH-1:0] seg_start_next;
  logic signed [LEVEL_WIDTH-1:0] seg_target_next;
  logic [SW-1:0]                 tick_sum;
  logic [EW-1:0]                 tick_elapsed;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_min   <= '0;
      level_max   <= {1'b0, {(LEVEL_WIDTH-1){1'b1}}};
      attack_len  <= '0;
      release_len <= '0;
      sustain_len <= ELAPSED_ALL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_MIN:   level_min   <= cfg_data[LEVEL_WIDTH-1:0];
        REG_LEVEL_MAX:   level_max   <= cfg_data[LEVEL_WIDTH-1:0];
        REG_ATTACK_LEN:  attack_len  <= cfg_data[TIME_WIDTH-1:0];
        REG_RELEASE_LEN: release_len <= cfg_data[TIME_WIDTH-1:0];
        REG_SUSTAIN_LEN: sustain_len <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // segment value without division: off, sustain, zero or expired duration
  always_comb begin
    dur       = (phase == PH_ATTACK) ? attack_len : release_len;
    at_target = !(phase == PH_ATTACK || phase == PH_RELEASE) ||
                (dur == '0) || (elapsed >= {1'b0, dur});
    diff      = {seg_target[LEVEL_WIDTH-1], seg_target} -
                {seg_start[LEVEL_WIDTH-1], seg_start};
    diff_abs  = diff[LEVEL_WIDTH] ? (~diff + 1'b1) : diff;
    product   = diff_abs[LEVEL_WIDTH-1:0] * elapsed[TIME_WIDTH-1:0];
  end

  assign sts.bypass   = at_target || (elapsed == '0);
  assign sts.need_pre = (cmd_q == CMD_ATTACK) || (cmd_q == CMD_RELEASE);

  // one restoring step: remainder in the upper bits, quotient shifts in below
  always_comb begin
    trial     = {div_reg[PW-1:LEVEL_WIDTH], div_reg[LEVEL_WIDTH-1]};
    trial_ge  = trial >= {1'b0, dur};
    trial_rem = trial_ge ? (trial - {1'b0, dur}) : trial;
  end

  // start plus or minus the quotient; always lies between start and target
  always_comb begin
    if (neg) begin
      interp = {seg_start[LEVEL_WIDTH-1], seg_start} - {1'b0, div_reg[LEVEL_WIDTH-1:0]};
    end else begin
      interp = {seg_start[LEVEL_WIDTH-1], seg_start} + {1'b0, div_reg[LEVEL_WIDTH-1:0]};
    end
  end

  // evaluation registers
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      neg     <= diff[LEVEL_WIDTH];
      div_reg <= product;
      if (at_target) begin
        cur_value <= seg_target;
      end else begin
        cur_value <= seg_start;
      end
    end else if (ctl.div_step) begin
      div_reg <= {trial_rem[TIME_WIDTH-1:0], div_reg[LEVEL_WIDTH-2:0], trial_ge};
    end else if (ctl.div_done) begin
      cur_value <= interp[LEVEL_WIDTH-1:0];
    end
  end

  // saturating time advance
  always_comb begin
    tick_sum = SW'(elapsed) + SW'(delta_q);
    if (tick_sum > SW'(ELAPSED_ALL)) begin
      tick_elapsed = ELAPSED_ALL;
    end else begin
      tick_elapsed = tick_sum[EW-1:0];
    end
  end

  // command application
  always_comb begin
    phase_next      = phase;
    elapsed_next    = elapsed;
    seg_start_next  = seg_start;
    seg_target_next = seg_target;
    case (cmd_q)
      CMD_TICK: begin
        if (phase == PH_ATTACK) begin
          if (tick_elapsed >= {1'b0, attack_len}) begin
            phase_next      = PH_SUSTAIN;
            elapsed_next    = '0;
            seg_start_next  = level_max;
            seg_target_next = level_max;
          end else begin
            elapsed_next = tick_elapsed;
          end
        end else if (phase == PH_SUSTAIN && !sustain_len[EW-1]) begin
          if (tick_elapsed >= sustain_len) begin
            elapsed_next = '0;
            if (release_len == '0) begin
              phase_next      = PH_OFF;
              seg_start_next  = level_min;
              seg_target_next = level_min;
            end else begin
              phase_next      = PH_RELEASE;
              seg_start_next  = seg_target;
              seg_target_next = level_min;
            end
          end else begin
            elapsed_next = tick_elapsed;
          end
        end else if (phase == PH_RELEASE) begin
          if (tick_elapsed >= {1'b0, release_len}) begin
            phase_next      = PH_OFF;
            elapsed_next    = '0;
            seg_start_next  = level_min;
            seg_target_next = level_min;
          end else begin
            elapsed_next = tick_elapsed;
          end
        end
      end
      CMD_ATTACK: begin
        elapsed_next = '0;
        if (attack_len == '0) begin
          phase_next      = PH_SUSTAIN;
          seg_start_next  = level_max;
          seg_target_next = level_max;
        end else begin
          phase_next      = PH_ATTACK;
          seg_start_next  = cur_value;
          seg_target_next = level_max;
        end
      end
      CMD_RELEASE: begin
        elapsed_next = '0;
        if (release_len == '0) begin
          phase_next      = PH_OFF;
          seg_start_next  = level_min;
          seg_target_next = level_min;
        end else begin
          phase_next      = PH_RELEASE;
          seg_start_next  = cur_value;
          seg_target_next = level_min;
        end
      end
      default: begin
        phase_next      = PH_OFF;
        elapsed_next    = '0;
        seg_start_next  = level_min;
        seg_target_next = level_min;
      end
    endcase
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OFF;
      elapsed    <= '0;
      seg_start  <= '0;
      seg_target <= '0;
    end else if (ctl.apply) begin
      phase      <= phase_next;
      elapsed    <= elapsed_next;
      seg_start  <= seg_start_next;
      seg_target <= seg_target_next;
    end
  end

  // command word capture and result register
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= command;
      delta_q <= delta_time;
    end
    if (ctl.out_load) begin
      level     <= cur_value;
      phase_out <= phase;
    end
  end

endmodule

// ===== design/teg_ctrl.sv =====
// ----------------------------------------------------------------------------
// teg_ctrl
// Sequencer: takes a command word, runs the optional pre-evaluation, applies
// the command, evaluates the new value and hands the result word out.
// ----------------------------------------------------------------------------
module teg_ctrl #(
  parameter int LEVEL_WIDTH = teg_pkg::LEVEL_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  output logic          result_valid,
  input  logic          result_ready,
  output teg_pkg::ctl_t ctl,
  input  teg_pkg::sts_t sts
);
  import teg_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEVEL_WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHOOSE,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_APPLY,
    S_PUT
  } state_t;

  state_t           state;
  logic             post;  // evaluation after apply feeds the result
  logic [CNT_W-1:0] step;
  logic             out_free;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  // datapath commands
  always_comb begin
    ctl          = '0;
    ctl.latch    = (state == S_IDLE) && item_valid;
    ctl.eval     = (state == S_EVAL);
    ctl.div_step = (state == S_DIV);
    ctl.div_done = (state == S_FIN);
    ctl.apply    = (state == S_APPLY);
    ctl.out_load = (state == S_PUT) && out_free;
  end

  // state, step count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      post         <= 1'b0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      // a new word replaces the one taken in the same cycle
      if (state == S_PUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_CHOOSE;
          end
        end
        S_CHOOSE: begin
          post <= !sts.need_pre;
          if (sts.need_pre) begin
            state <= S_EVAL;
          end else begin
            state <= S_APPLY;
          end
        end
        S_EVAL: begin
          step <= '0;
          if (!sts.bypass) begin
            state <= S_DIV;
          end else if (post) begin
            state <= S_PUT;
          end else begin
            state <= S_APPLY;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (post) begin
            state <= S_PUT;
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          post  <= 1'b1;
          state <= S_EVAL;
        end
        S_PUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/trapezoid_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// trapezoid_envelope_generator
// Linear attack-sustain-release envelope driven by command words.
// ----------------------------------------------------------------------------
// Each command word (tick, start attack, start release, reset to off) yields
// one result word with the envelope level and phase after the command. Words
// are handled one at a time. A word whose value lies inside an attack or
// release ramp is worked out by the restoring divider, which yields one
// quotient bit per cycle for the interpolation |target - start| * elapsed /
// duration; when the value sits at a segment end, at its start or in
// off/sustain, the division is skipped. A start command also evaluates the
// present value before it is applied; a tick or reset does not. A finished
// result waits in an output register, so a new command word is taken while
// it is still pending. Register writes are taken every cycle and must only
// occur while no command word is in flight.
// ----------------------------------------------------------------------------
module trapezoid_envelope_generator #(
  parameter int TIME_WIDTH  = teg_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = teg_pkg::LEVEL_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  teg_in_if.sink    item,
  teg_out_if.source result,
  teg_cfg_if.sink   cfg
);
  import teg_pkg::*;

  localparam int CFG_DW = (LEVEL_WIDTH > TIME_WIDTH + 1) ? LEVEL_WIDTH : TIME_WIDTH + 1;

  ctl_t ctl;
  sts_t sts;

  // registers are always writable
  assign cfg.ready = 1'b1;

  teg_ctrl #(
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .ctl          (ctl),
    .sts          (sts)
  );

  teg_datapath #(
    .TIME_WIDTH  (TIME_WIDTH),
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .CFG_DW      (CFG_DW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .command    (item.command),
    .delta_time (item.delta_time),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data[CFG_DW-1:0]),
    .level      (result.level),
    .phase_out  (result.phase_out)
  );

endmodule

// ===== design/teg_checker.sv =====
// ----------------------------------------------------------------------------
// teg_checker
// Port-level checks on the envelope generator: word accounting, one word in
// work at a time, result hold under backpressure and quiet after reset.
// ----------------------------------------------------------------------------
module teg_checker #(
  parameter int LEVEL_WIDTH = teg_pkg::LEVEL_WIDTH_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic signed [LEVEL_WIDTH-1:0]       level,
  input logic [teg_pkg::PHASE_WIDTH-1:0]     phase_out
);
  import teg_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;  // accepted words whose result is not yet taken

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // at most one word in work plus one waiting result
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more words outstanding than the block can hold");

  // a result only for an accepted word
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result word without an accepted command word");

  // a command word is worked on alone
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !item_ready)
    else $error("command word taken while the previous one is in work");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(level) && $stable(phase_out))
    else $error("stalled result word changed");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind trapezoid_envelope_generator teg_checker #(
  .LEVEL_WIDTH (LEVEL_WIDTH)
) u_teg_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .level        (result.level),
  .phase_out    (result.phase_out)
);
